// ===== hdl/hcma_pkg.sv =====
`timescale 1ns / 1ps
package hcma_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         sensor_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] hit_time;
    logic [15:0]        amplitude;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_neighbor;
    logic [6:0]         hit_count;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] weighted_x;
    logic signed [15:0] weighted_y;
    logic [21:0]        total_charge;
    logic signed [15:0] mean_time;
    logic [15:0]        mean_amplitude;
    logic [15:0]        time_rms;
    logic [15:0]        amplitude_rms;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ISSUE,
    S_SCAN_CHECK,
    S_SQ,
    S_SHIFT_ISSUE,
    S_SHIFT_WRITE,
    S_UPDATE,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_SQRT_LOAD,
    S_SQRT_RUN,
    S_DONE
  } state_t;

  localparam int SUM_W    = 48;
  localparam int DIV_BITS = 48;
  localparam int NUM_QUOT = 8;
  localparam int NUM_ROOT = 2;

endpackage

// ===== hdl/hit_cluster_moment_accumulator.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready | hcma_pkg::in_item_t
// out     | output    | out_valid/out_ready | hcma_pkg::out_item_t
// cfg     | input     | cfg_we              | neighbor_radius, 16 bit
// One item per transaction; remove and query read the stored hits one by one, issuing
// each read and then checking it, and remove then shifts each later hit down by a read
// and a write. Eight quotients follow on one shared restoring divider, then two roots.
// Most of the time from acceptance to result is spent in the serial divider.
// Synchronous reset empties the cluster and zeroes the sums and the radius.
// A new item is taken once the previous result has left the output register.
module hit_cluster_moment_accumulator #(
  parameter int MAX_HITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hcma_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hcma_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);

  localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int SW = hcma_pkg::SUM_W;
  localparam int DB = hcma_pkg::DIV_BITS;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         id;
  } pos_ent_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic [15:0]        a;
  } sig_ent_t;

  pos_ent_t pos_mem [MAX_HITS];
  sig_ent_t sig_mem [MAX_HITS];
  pos_ent_t pos_rd;
  sig_ent_t sig_rd;
  logic            mem_we;
  logic [AW-1:0]   wr_addr, rd_addr;
  pos_ent_t        pos_wd;
  sig_ent_t        sig_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[wr_addr] <= pos_wd;
      sig_mem[wr_addr] <= sig_wd;
    end
    pos_rd <= pos_mem[rd_addr];
    sig_rd <= sig_mem[rd_addr];
  end

  hcma_pkg::state_t state, state_next;
  hcma_pkg::in_item_t item;
  logic [15:0] radius;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic signed [SW-1:0] sum_x, sum_y, sum_ax, sum_ay, sum_t;
  logic [SW-1:0] sum_a, sum_tsq, sum_asq;
  logic [1:0] status;
  logic nb, found;
  logic [33:0] d2;
  logic [31:0] r2;
  logic signed [SW-1:0] p_ax, p_ay;
  logic [SW-1:0] p_tsq, p_asq;
  logic [2:0] qsel;
  logic [5:0] step;
  logic [DB-1:0] rem, quo, den;
  logic neg;
  logic [15:0] quots [hcma_pkg::NUM_QUOT];
  logic [DB-1:0] sq_v, sq_res, sq_bit;
  logic rsel;
  logic [15:0] roots [hcma_pkg::NUM_ROOT];
  logic [DB-1:0] q_tsq, q_asq;
  hcma_pkg::out_item_t res;

  assign in_ready = (state == hcma_pkg::S_IDLE) && !out_valid;
  assign out_data = res;

  always_comb begin
    state_next = state;
    unique case (state)
      hcma_pkg::S_IDLE: if (in_valid && in_ready) begin
        unique case (hcma_pkg::kind_t'(in_data.kind))
          hcma_pkg::KIND_INSERT: state_next = hcma_pkg::S_SQ;
          hcma_pkg::KIND_REMOVE, hcma_pkg::KIND_QUERY: state_next = hcma_pkg::S_SCAN_ISSUE;
          default: state_next = hcma_pkg::S_DIV_LOAD;
        endcase
      end
      hcma_pkg::S_SCAN_ISSUE: state_next = (idx >= count) ? hcma_pkg::S_DIV_LOAD
                                                         : hcma_pkg::S_SCAN_CHECK;
      hcma_pkg::S_SCAN_CHECK: begin
        if (item.kind == hcma_pkg::KIND_REMOVE && pos_rd.id == item.sensor_id)
          state_next = hcma_pkg::S_SQ;
        else if (item.kind == hcma_pkg::KIND_QUERY && {2'b0, r2} > d2)
          state_next = hcma_pkg::S_DIV_LOAD;
        else
          state_next = hcma_pkg::S_SCAN_ISSUE;
      end
      hcma_pkg::S_SQ: begin
        if (status == hcma_pkg::ST_FULL)
          state_next = hcma_pkg::S_DIV_LOAD;
        else
          state_next = found ? hcma_pkg::S_SHIFT_ISSUE : hcma_pkg::S_UPDATE;
      end
      hcma_pkg::S_SHIFT_ISSUE: state_next = (idx + 1'b1 >= count) ? hcma_pkg::S_UPDATE
                                                               : hcma_pkg::S_SHIFT_WRITE;
      hcma_pkg::S_SHIFT_WRITE: state_next = hcma_pkg::S_SHIFT_ISSUE;
      hcma_pkg::S_UPDATE: state_next = hcma_pkg::S_DIV_LOAD;
      hcma_pkg::S_DIV_LOAD: state_next = hcma_pkg::S_DIV_RUN;
      hcma_pkg::S_DIV_RUN: if (step == 6'd0)
        state_next = (qsel == 3'(hcma_pkg::NUM_QUOT - 1)) ? hcma_pkg::S_SQRT_LOAD
                                                          : hcma_pkg::S_DIV_LOAD;
      hcma_pkg::S_SQRT_LOAD: state_next = hcma_pkg::S_SQRT_RUN;
      hcma_pkg::S_SQRT_RUN: if (sq_bit == '0)
        state_next = rsel ? hcma_pkg::S_DONE : hcma_pkg::S_SQRT_LOAD;
      hcma_pkg::S_DONE: state_next = hcma_pkg::S_IDLE;
      default: state_next = hcma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx[AW-1:0];
    rd_addr = idx[AW-1:0];
    pos_wd  = pos_rd;
    sig_wd  = sig_rd;
    unique case (state)
      hcma_pkg::S_SQ: if (!found) begin
        mem_we = (item.kind == hcma_pkg::KIND_INSERT) && (status != hcma_pkg::ST_FULL);
        pos_wd = '{x: item.pos_x, y: item.pos_y, id: item.sensor_id};
        sig_wd = '{t: item.hit_time, a: item.amplitude};
      end
      hcma_pkg::S_SHIFT_ISSUE: rd_addr = AW'(idx + 1'b1);
      hcma_pkg::S_SHIFT_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    logic signed [16:0] ddx, ddy;
    ddx = 17'(item.pos_x) - 17'(pos_rd.x);
    ddy = 17'(item.pos_y) - 17'(pos_rd.y);
    d2 = 34'(ddx * ddx) + 34'(ddy * ddy);
  end

  // divider numerator / denominator selection
  logic signed [SW-1:0] num_s;
  logic [SW-1:0] den_s;
  always_comb begin
    num_s = '0;
    den_s = SW'(count);
    case (qsel)
      3'd0: num_s = sum_x;
      3'd1: num_s = sum_y;
      3'd2: begin num_s = sum_ax; den_s = sum_a; end
      3'd3: begin num_s = sum_ay; den_s = sum_a; end
      3'd4: num_s = sum_t;
      3'd5: num_s = sum_a;
      3'd6: num_s = sum_tsq;
      default: num_s = sum_asq;
    endcase
  end

  logic [DB:0] trial;
  assign trial = {rem[DB-2:0], quo[DB-1]} - {1'b0, den};
  logic [DB-1:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcma_pkg::S_IDLE;
      out_valid <= 1'b0;
      radius <= '0;
      count <= '0;
      sum_x <= '0; sum_y <= '0; sum_ax <= '0; sum_ay <= '0; sum_t <= '0;
      sum_a <= '0; sum_tsq <= '0; sum_asq <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) radius <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        hcma_pkg::S_IDLE: if (in_valid && in_ready) begin
          item <= in_data;
          nb <= 1'b0;
          found <= 1'b0;
          qsel <= '0;
          rsel <= 1'b0;
          r2 <= radius * radius;
          idx <= (in_data.kind == hcma_pkg::KIND_INSERT) ? count : '0;
          if (in_data.kind == hcma_pkg::KIND_REMOVE)
            status <= hcma_pkg::ST_NOT_FOUND;
          else if (in_data.kind == hcma_pkg::KIND_INSERT && count >= CW'(MAX_HITS))
            status <= hcma_pkg::ST_FULL;
          else
            status <= hcma_pkg::ST_OK;
          if (in_data.kind == hcma_pkg::KIND_CLEAR) begin
            count <= '0;
            sum_x <= '0; sum_y <= '0; sum_ax <= '0; sum_ay <= '0; sum_t <= '0;
            sum_a <= '0; sum_tsq <= '0; sum_asq <= '0;
          end
        end
        hcma_pkg::S_SCAN_CHECK: begin
          if (item.kind == hcma_pkg::KIND_REMOVE && pos_rd.id == item.sensor_id) begin
            found <= 1'b1;
            status <= hcma_pkg::ST_OK;
            item.pos_x <= pos_rd.x;
            item.pos_y <= pos_rd.y;
            item.hit_time <= sig_rd.t;
            item.amplitude <= sig_rd.a;
          end else if (item.kind == hcma_pkg::KIND_QUERY && {2'b0, r2} > d2) begin
            nb <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        hcma_pkg::S_SQ: begin
          p_ax <= SW'($signed({1'b0, item.amplitude}) * item.pos_x);
          p_ay <= SW'($signed({1'b0, item.amplitude}) * item.pos_y);
          p_tsq <= SW'(item.hit_time * item.hit_time);
          p_asq <= SW'(item.amplitude * item.amplitude);
        end
        hcma_pkg::S_SHIFT_WRITE: idx <= idx + 1'b1;
        hcma_pkg::S_UPDATE: begin
          if (found) begin
            count <= count - 1'b1;
            sum_x <= sum_x - SW'(item.pos_x);
            sum_y <= sum_y - SW'(item.pos_y);
            sum_t <= sum_t - SW'(item.hit_time);
            sum_a <= sum_a - SW'(item.amplitude);
            sum_ax <= sum_ax - p_ax; sum_ay <= sum_ay - p_ay;
            sum_tsq <= sum_tsq - p_tsq; sum_asq <= sum_asq - p_asq;
          end else begin
            count <= count + 1'b1;
            sum_x <= sum_x + SW'(item.pos_x);
            sum_y <= sum_y + SW'(item.pos_y);
            sum_t <= sum_t + SW'(item.hit_time);
            sum_a <= sum_a + SW'(item.amplitude);
            sum_ax <= sum_ax + p_ax; sum_ay <= sum_ay + p_ay;
            sum_tsq <= sum_tsq + p_tsq; sum_asq <= sum_asq + p_asq;
          end
        end
        hcma_pkg::S_DIV_LOAD: begin
          neg <= num_s[SW-1] && (qsel <= 3'd4);
          quo <= (num_s[SW-1] && qsel <= 3'd4) ? DB'(-num_s) : DB'(num_s);
          den <= DB'(den_s);
          rem <= '0;
          step <= 6'(DB);
        end
        hcma_pkg::S_DIV_RUN: begin
          if (step != 6'd0) begin
            if (!trial[DB]) begin
              rem <= trial[DB-1:0];
              quo <= {quo[DB-2:0], 1'b1};
            end else begin
              rem <= {rem[DB-2:0], quo[DB-1]};
              quo <= {quo[DB-2:0], 1'b0};
            end
            step <= step - 1'b1;
          end else begin
            quots[qsel] <= (den == '0) ? 16'd0 : (neg ? 16'(-quo) : quo[15:0]);
            qsel <= qsel + 1'b1;
          end
        end
        hcma_pkg::S_SQRT_LOAD: begin
          sq_v <= rsel ? q_asq : q_tsq;
          sq_res <= '0;
          sq_bit <= DB'(1) << (DB - 2);
        end
        hcma_pkg::S_SQRT_RUN: begin
          if (sq_bit != '0) begin
            if (sq_v >= sq_try) begin
              sq_v <= sq_v - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            roots[rsel] <= sq_res[15:0];
            rsel <= 1'b1;
          end
        end
        hcma_pkg::S_DONE: begin
          out_valid <= 1'b1;
          res.status <= status;
          res.is_neighbor <= nb;
          res.hit_count <= (count > CW'(127)) ? 7'd127 : 7'(count);
          res.mean_x <= quots[0];
          res.mean_y <= quots[1];
          res.weighted_x <= quots[2];
          res.weighted_y <= quots[3];
          res.total_charge <= (sum_a > SW'(22'h3FFFFF)) ? 22'h3FFFFF : sum_a[21:0];
          res.mean_time <= quots[4];
          res.mean_amplitude <= quots[5];
          res.time_rms <= roots[0];
          res.amplitude_rms <= roots[1];
        end
        default: ;
      endcase
    end
  end

  // full square quotients are kept whole for the root stage
  always_ff @(posedge clk) begin
    if (state == hcma_pkg::S_DIV_RUN && step == 6'd0) begin
      if (qsel == 3'd6) q_tsq <= (den == '0) ? '0 : quo;
      if (qsel == 3'd7) q_asq <= (den == '0) ? '0 : quo;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_HITS))
    else $error("hit count beyond store depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == hcma_pkg::S_DONE) |=> out_valid)
    else $error("result not presented");

endmodule

// ===== sim/hit_cluster_moment_accumulator_tb.sv =====
`timescale 1ns / 1ps
module hit_cluster_moment_accumulator_tb;

  localparam int HIT_CAP = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam longint CYCLE_LIMIT = 64'd4000000;
  localparam int IN_W = $bits(hcma_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hcma_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hcma_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  hit_cluster_moment_accumulator #(.MAX_HITS(HIT_CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cluster shadow
  logic signed [15:0] shadow_x[$], shadow_y[$], shadow_t[$];
  logic [15:0] shadow_amp[$];
  logic [9:0] shadow_id[$];
  logic [15:0] radius = '0;

  hcma_pkg::in_item_t pending_items[$];
  hcma_pkg::out_item_t expected_moments[$];
  int errors = 0;
  int sent_items = 0;
  int checked_results = 0;
  int full_rejects = 0;
  int missed_removes = 0;
  int neighbor_hits = 0;
  longint cycle_count = 0;
  bit stimulus_done = 1'b0;

  function automatic longint quot_trunc(longint num, longint den);
    longint mag;
    if (den == 0) return 0;
    mag = (num < 0) ? -num : num;
    mag = mag / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, c;
    int i;
    r = 0;
    for (i = 20; i >= 0; i--) begin
      c = r | (longint'(1) << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic hcma_pkg::out_item_t predict_moments(hcma_pkg::in_item_t it);
    hcma_pkg::out_item_t res;
    longint sx, sy, sax, say, sa, st, stt, saa, n, r2, dx, dy;
    int k;
    sx = 0; sy = 0; sax = 0; say = 0; sa = 0; st = 0; stt = 0; saa = 0;
    res = '0;
    res.status = hcma_pkg::ST_OK;
    case (hcma_pkg::kind_t'(it.kind))
      hcma_pkg::KIND_INSERT: begin
        if (shadow_x.size() >= HIT_CAP) begin
          res.status = hcma_pkg::ST_FULL;
        end else begin
          shadow_x.push_back(it.pos_x);
          shadow_y.push_back(it.pos_y);
          shadow_t.push_back(it.hit_time);
          shadow_amp.push_back(it.amplitude);
          shadow_id.push_back(it.sensor_id);
        end
      end
      hcma_pkg::KIND_REMOVE: begin
        res.status = hcma_pkg::ST_NOT_FOUND;
        for (k = 0; k < shadow_id.size(); k++) begin
          if (shadow_id[k] == it.sensor_id) begin
            shadow_x.delete(k); shadow_y.delete(k); shadow_t.delete(k);
            shadow_amp.delete(k); shadow_id.delete(k);
            res.status = hcma_pkg::ST_OK;
            break;
          end
        end
      end
      hcma_pkg::KIND_QUERY: begin
        r2 = longint'(radius) * longint'(radius);
        for (k = 0; k < shadow_x.size(); k++) begin
          dx = longint'(it.pos_x) - longint'(shadow_x[k]);
          dy = longint'(it.pos_y) - longint'(shadow_y[k]);
          if (dx * dx + dy * dy < r2) begin
            res.is_neighbor = 1'b1;
            break;
          end
        end
      end
      default: begin
        shadow_x.delete(); shadow_y.delete(); shadow_t.delete();
        shadow_amp.delete(); shadow_id.delete();
      end
    endcase
    n = shadow_x.size();
    for (k = 0; k < n; k++) begin
      sx += shadow_x[k];
      sy += shadow_y[k];
      sax += longint'(shadow_amp[k]) * shadow_x[k];
      say += longint'(shadow_amp[k]) * shadow_y[k];
      sa += shadow_amp[k];
      st += shadow_t[k];
      stt += longint'(shadow_t[k]) * shadow_t[k];
      saa += longint'(shadow_amp[k]) * shadow_amp[k];
    end
    res.hit_count = (n > 127) ? 7'd127 : 7'(n);
    res.mean_x = 16'(quot_trunc(sx, n));
    res.mean_y = 16'(quot_trunc(sy, n));
    res.weighted_x = 16'(quot_trunc(sax, sa));
    res.weighted_y = 16'(quot_trunc(say, sa));
    res.total_charge = (sa > 64'h3FFFFF) ? 22'h3FFFFF : 22'(sa);
    res.mean_time = 16'(quot_trunc(st, n));
    res.mean_amplitude = 16'(quot_trunc(sa, n));
    res.time_rms = 16'(floor_sqrt(quot_trunc(stt, n)));
    res.amplitude_rms = 16'(floor_sqrt(quot_trunc(saa, n)));
    return res;
  endfunction

  int in_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else if (in_wait > 0) begin
      in_valid <= 1'b0;
      in_wait <= in_wait - 1;
    end else if (pending_items.size() > 0) begin
      in_data <= pending_items[0];
      expected_moments.push_back(predict_moments(pending_items[0]));
      pending_items.pop_front();
      in_valid <= 1'b1;
      sent_items <= sent_items + 1;
      in_wait <= $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  int out_wait = 0;
  int out_draw = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_moments.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          hcma_pkg::out_item_t e;
          e = expected_moments.pop_front();
          if (out_data.status != e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++; end
          if (out_data.is_neighbor != e.is_neighbor) begin
            $error("is_neighbor exp %0d got %0d", e.is_neighbor, out_data.is_neighbor);
            errors++; end
          if (out_data.hit_count != e.hit_count) begin
            $error("hit_count exp %0d got %0d", e.hit_count, out_data.hit_count); errors++; end
          if (out_data.mean_x != e.mean_x) begin
            $error("mean_x exp %0d got %0d", e.mean_x, out_data.mean_x); errors++; end
          if (out_data.mean_y != e.mean_y) begin
            $error("mean_y exp %0d got %0d", e.mean_y, out_data.mean_y); errors++; end
          if (out_data.weighted_x != e.weighted_x) begin
            $error("weighted_x exp %0d got %0d", e.weighted_x, out_data.weighted_x);
            errors++; end
          if (out_data.weighted_y != e.weighted_y) begin
            $error("weighted_y exp %0d got %0d", e.weighted_y, out_data.weighted_y);
            errors++; end
          if (out_data.total_charge != e.total_charge) begin
            $error("total_charge exp %0d got %0d", e.total_charge, out_data.total_charge);
            errors++; end
          if (out_data.mean_time != e.mean_time) begin
            $error("mean_time exp %0d got %0d", e.mean_time, out_data.mean_time); errors++; end
          if (out_data.mean_amplitude != e.mean_amplitude) begin
            $error("mean_amplitude exp %0d got %0d", e.mean_amplitude,
                   out_data.mean_amplitude); errors++; end
          if (out_data.time_rms != e.time_rms) begin
            $error("time_rms exp %0d got %0d", e.time_rms, out_data.time_rms); errors++; end
          if (out_data.amplitude_rms != e.amplitude_rms) begin
            $error("amplitude_rms exp %0d got %0d", e.amplitude_rms,
                   out_data.amplitude_rms); errors++; end
          if (e.status == hcma_pkg::ST_FULL) full_rejects++;
          if (e.status == hcma_pkg::ST_NOT_FOUND) missed_removes++;
          if (e.is_neighbor) neighbor_hits++;
          checked_results++;
        end
        out_draw = $urandom_range(0, 3);
        out_wait <= out_draw;
        out_ready <= (out_draw == 0);
      end else if (out_valid && !out_ready) begin
        if (out_wait > 1) begin
          out_wait <= out_wait - 1;
        end else begin
          out_wait <= 0;
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic hcma_pkg::in_item_t make_item(hcma_pkg::kind_t k, logic [9:0] id,
                                                   logic [15:0] x, logic [15:0] y,
                                                   logic [15:0] t, logic [15:0] a);
    hcma_pkg::in_item_t it;
    it.kind = k; it.sensor_id = id; it.pos_x = x; it.pos_y = y;
    it.hit_time = t; it.amplitude = a;
    return it;
  endfunction

  function automatic hcma_pkg::in_item_t random_item(int ids);
    hcma_pkg::in_item_t it;
    int sel;
    it = hcma_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 55) it.kind = hcma_pkg::KIND_INSERT;
    else if (sel < 75) it.kind = hcma_pkg::KIND_REMOVE;
    else if (sel < 97) it.kind = hcma_pkg::KIND_QUERY;
    else it.kind = hcma_pkg::KIND_CLEAR;
    if (ids > 0 && $urandom_range(0, 9) != 0) it.sensor_id = 10'($urandom_range(0, ids - 1));
    if ($urandom_range(0, 2) == 0) begin
      it.pos_x = 16'($signed(10'($urandom)));
      it.pos_y = 16'($signed(10'($urandom)));
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_moments.size() > 0 || in_valid)
      @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= r;
    radius = r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k, ph;
    logic [15:0] radii[5];
    radii = '{16'd0, 16'hFFFF, 16'd40, 16'd800, 16'd1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_radius(16'd64);
    pending_items.push_back(make_item(hcma_pkg::KIND_QUERY, 10'd0, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_REMOVE, 10'd5, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_INSERT, 10'h3FF, 16'h7FFF, 16'h8000,
                                      16'h8000, 16'hFFFF));
    pending_items.push_back(make_item(hcma_pkg::KIND_INSERT, 10'h000, 16'h8000, 16'h7FFF,
                                      16'h7FFF, 16'h0000));
    pending_items.push_back(make_item(hcma_pkg::KIND_INSERT, 10'h3FF, 16'hFFF0, 16'h0010,
                                      16'hFFFF, 16'h0001));
    pending_items.push_back(make_item(hcma_pkg::KIND_QUERY, 10'd0, 16'hFFD0, 16'h0040,
                                      16'd0, 16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_QUERY, 10'd0, 16'h1000, 16'h1000,
                                      16'd0, 16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_REMOVE, 10'h3FF, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_REMOVE, 10'h155, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    pending_items.push_back(make_item(hcma_pkg::KIND_CLEAR, 10'd0, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    for (k = 0; k < HIT_CAP + 2; k++)
      pending_items.push_back(make_item(hcma_pkg::KIND_INSERT, 10'(k), 16'(k * 16), 16'(-k),
                                        16'(k), 16'($urandom)));
    pending_items.push_back(make_item(hcma_pkg::KIND_CLEAR, 10'd0, 16'd0, 16'd0, 16'd0,
                                      16'd0));
    wait_drained();
    for (ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      for (k = 0; k < RANDOM_ITEMS / 5; k++)
        pending_items.push_back(random_item(ph == 4 ? 0 : 48));
      wait_drained();
    end
    $display("tb: %0d items, %0d results checked, radius extremes and five settings",
             sent_items, checked_results);
    $display("tb: %0d full-store rejects, %0d missed removes, %0d neighbour hits",
             full_rejects, missed_removes, neighbor_hits);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
